[rtl/gsp_pkg.sv]
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared types and constants for the braced GUID string parser.
// ----------------------------------------------------------------------------
package gsp_pkg;

    // Text layout of a braced GUID: {XXXXXXXX-XXXX-XXXX-XXXX-XXXXXXXXXXXX}
    localparam int unsigned POS_W        = 6;
    localparam int unsigned CODE_W       = 16;
    localparam int unsigned VALUE_W      = 128;
    localparam logic [POS_W-1:0] TEXT_LEN     = 6'd38;
    localparam logic [POS_W-1:0] POS_OPEN     = 6'd0;
    localparam logic [POS_W-1:0] POS_CLOSE    = 6'd37;
    localparam logic [POS_W-1:0] POS_DASH_A   = 6'd9;
    localparam logic [POS_W-1:0] POS_DASH_B   = 6'd14;
    localparam logic [POS_W-1:0] POS_DASH_C   = 6'd19;
    localparam logic [POS_W-1:0] POS_DASH_D   = 6'd24;
    localparam logic [POS_W-1:0] POS_SATURATE = 6'd39;

    // Character codes
    localparam logic [CODE_W-1:0] CHAR_LBRACE = 16'h007B;
    localparam logic [CODE_W-1:0] CHAR_RBRACE = 16'h007D;
    localparam logic [CODE_W-1:0] CHAR_DASH   = 16'h002D;
    localparam logic [CODE_W-1:0] CHAR_ZERO   = 16'h0030;
    localparam logic [CODE_W-1:0] CHAR_NINE   = 16'h0039;
    localparam logic [CODE_W-1:0] CHAR_LC_A   = 16'h0061;
    localparam logic [CODE_W-1:0] CHAR_LC_F   = 16'h0066;
    localparam logic [CODE_W-1:0] CHAR_UC_A   = 16'h0041;
    localparam logic [CODE_W-1:0] CHAR_UC_F   = 16'h0046;
    localparam logic [CODE_W-1:0] HEX_ALPHA_BASE = 16'd10;

    // Result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    // Input transfer payload
    typedef struct packed {
        logic [CODE_W-1:0] char_code;
        logic              last;
    } in_item_t;

    // Output transfer payload
    typedef struct packed {
        logic [31:0] data1;
        logic [15:0] data2;
        logic [15:0] data3;
        logic [63:0] data4;
        logic        status;
    } out_item_t;

    // Classification of one character at its position
    typedef struct packed {
        logic       shift_en;
        logic [3:0] nibble;
        logic       bad;
    } char_class_t;

endpackage

[rtl/gsp_char_decode.sv]
// ----------------------------------------------------------------------------
// gsp_char_decode
// Checks one character against the layout at its position and decodes hex.
// ----------------------------------------------------------------------------
module gsp_char_decode
    import gsp_pkg::*;
(
    input  logic [CODE_W-1:0] char_code,
    input  logic [POS_W-1:0]  position,
    output char_class_t       char_class
);

    logic is_dec;
    logic is_lc;
    logic is_uc;
    logic is_dash_pos;
    logic [CODE_W-1:0] digit_val;

    // Detect digit ranges
    assign is_dec = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign is_lc  = (char_code >= CHAR_LC_A) && (char_code <= CHAR_LC_F);
    assign is_uc  = (char_code >= CHAR_UC_A) && (char_code <= CHAR_UC_F);

    assign is_dash_pos = (position == POS_DASH_A) || (position == POS_DASH_B) ||
                         (position == POS_DASH_C) || (position == POS_DASH_D);

    // Decode the nibble value
    always_comb
    begin
        priority if (is_dec)
        begin
            digit_val = char_code - CHAR_ZERO;
        end
        else if (is_lc)
        begin
            digit_val = char_code - CHAR_LC_A + HEX_ALPHA_BASE;
        end
        else if (is_uc)
        begin
            digit_val = char_code - CHAR_UC_A + HEX_ALPHA_BASE;
        end
        else
        begin
            digit_val = '0;
        end
    end

    // Check the character against its position
    always_comb
    begin
        char_class.shift_en = 1'b0;
        char_class.nibble   = 4'd0;
        char_class.bad      = 1'b0;
        priority if (position >= TEXT_LEN)
        begin
            char_class.bad = 1'b1;
        end
        else if (position == POS_OPEN)
        begin
            char_class.bad = (char_code != CHAR_LBRACE);
        end
        else if (position == POS_CLOSE)
        begin
            char_class.bad = (char_code != CHAR_RBRACE);
        end
        else if (is_dash_pos)
        begin
            char_class.bad = (char_code != CHAR_DASH);
        end
        else
        begin
            char_class.shift_en = 1'b1;
            char_class.nibble   = digit_val[3:0];
            char_class.bad      = !(is_dec || is_lc || is_uc);
        end
    end

endmodule

[rtl/gsp_out_reg.sv]
// ----------------------------------------------------------------------------
// gsp_out_reg
// Result register that parts the parser from the downstream receiver.
// ----------------------------------------------------------------------------
module gsp_out_reg
    import gsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_item_t load_data,
    output logic      can_load,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    // Accept a new result when empty or when the held one transfers now
    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/guid_string_parser_top.sv]
// ----------------------------------------------------------------------------
// guid_string_parser_top
// Parses a braced GUID string, one UTF-16 code unit per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   The in channel carries one character per transfer with a last flag. The
//   out channel carries one result per string, on the character marked last:
//   the four GUID fields and a status (0 parsed, 1 invalid with zero fields).
//   A string of the wrong length, or with any wrong brace, dash or non-hex
//   character, reports invalid.
// Timing:
//   One character per cycle sustained, unless a last character waits for a
//   full output register. A character sits in the input register, where
//   the position check, nibble decode and 128-bit shift run; the result is
//   registered in the output register when the last character leaves it.
// Reset and stall:
//   Reset clears the position, the shift value, the error flag and both
//   valid flags. While the receiver stalls, the held result waits in the
//   output register; characters that give no result keep flowing, and a
//   last character waits in the input register until the output is free.
// ----------------------------------------------------------------------------
module guid_string_parser_top
    import gsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic               stage_valid_reg;
    logic               stage_valid_next;
    in_item_t           stage_data_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [VALUE_W-1:0] shift_reg;
    logic [VALUE_W-1:0] shift_next;
    logic               bad_reg;
    logic               bad_next;
    char_class_t        char_class;
    logic               can_load;
    logic               advance;
    logic               in_xfer;
    logic               final_bad;
    out_item_t          result;

    // Decode the staged character
    gsp_char_decode u_decode (
        .char_code  (stage_data_reg.char_code),
        .position   (pos_reg),
        .char_class (char_class)
    );

    // Advance the stage unless a result is due and the output is full
    assign advance  = stage_valid_reg && (!stage_data_reg.last || can_load);
    assign in_ready = !stage_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_xfer)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
    end

    // Update parse state for the advancing character
    always_comb
    begin
        pos_next   = pos_reg;
        shift_next = shift_reg;
        bad_next   = bad_reg;
        if (advance)
        begin
            if (char_class.shift_en)
            begin
                shift_next = {shift_reg[VALUE_W-5:0], char_class.nibble};
            end
            bad_next = bad_reg || char_class.bad;
            if (pos_reg < POS_SATURATE)
            begin
                pos_next = pos_reg + 6'd1;
            end
            if (stage_data_reg.last)
            begin
                pos_next   = '0;
                shift_next = '0;
                bad_next   = 1'b0;
            end
        end
    end

    // Build the result from the shift value; a valid string ends on the
    // closing brace, which shifts nothing
    assign final_bad = bad_reg || char_class.bad || (pos_reg != POS_CLOSE);

    always_comb
    begin
        if (final_bad)
        begin
            result.data1  = '0;
            result.data2  = '0;
            result.data3  = '0;
            result.data4  = '0;
            result.status = STATUS_INVALID;
        end
        else
        begin
            result.data1  = shift_reg[VALUE_W-1:VALUE_W-32];
            result.data2  = shift_reg[VALUE_W-33:VALUE_W-48];
            result.data3  = shift_reg[VALUE_W-49:VALUE_W-64];
            result.data4  = shift_reg[VALUE_W-65:0];
            result.status = STATUS_OK;
        end
    end

    // Hold the result for the receiver
    gsp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && stage_data_reg.last),
        .load_data (result),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            pos_reg         <= '0;
            shift_reg       <= '0;
            bad_reg         <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            pos_reg         <= pos_next;
            shift_reg       <= shift_next;
            bad_reg         <= bad_next;
        end
    end

    // Capture the incoming character
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            stage_data_reg <= in_data;
        end
    end

    // Position never passes its saturation point
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_SATURATE)
        else $error("character position beyond saturation");

    // An invalid result carries all-zero fields
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == STATUS_INVALID) |->
        (out_data.data1 == '0 && out_data.data2 == '0 &&
         out_data.data3 == '0 && out_data.data4 == '0))
        else $error("invalid result with nonzero fields");

    // A finished string leaves the parse state cleared
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stage_data_reg.last) |=> (pos_reg == '0 && !bad_reg))
        else $error("parse state not cleared after last character");

    // A last character advances only into a free result register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stage_data_reg.last && out_valid) |-> out_ready)
        else $error("result overwritten before transfer");

    // Input stalls only behind a staged last character and a held result
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (stage_valid_reg && stage_data_reg.last && out_valid))
        else $error("input stalled without cause");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the braced GUID string parser. It streams strings one
// character per transfer, from clean GUIDs through broken, short, long and
// random ones. It tracks the parser state on its own to predict each result,
// and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top
    import gsp_pkg::*;
();

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    // Idle rates in percent, set per phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    int unsigned char_count = 0;
    int unsigned string_count = 0;
    int unsigned fail_count = 0;

    // Parser state as predicted
    logic [POS_W-1:0] guess_pos = '0;
    logic [63:0]      guess_high = '0;
    logic [63:0]      guess_low = '0;
    logic             guess_bad = 1'b0;

    out_item_t guid_results_due[$];
    logic [CODE_W-1:0] text_buf[$];

    guid_string_parser_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Decode one hex digit; bit 4 set means not a digit
    function automatic logic [4:0] decode_hex(input logic [CODE_W-1:0] code);
        logic [4:0] nib;
        nib = 5'h10;
        if (code >= CHAR_ZERO && code <= CHAR_NINE)
            nib = 5'(code - CHAR_ZERO);
        else if (code >= CHAR_LC_A && code <= CHAR_LC_F)
            nib = 5'(code - CHAR_LC_A + HEX_ALPHA_BASE);
        else if (code >= CHAR_UC_A && code <= CHAR_UC_F)
            nib = 5'(code - CHAR_UC_A + HEX_ALPHA_BASE);
        return nib;
    endfunction

    function automatic logic [CODE_W-1:0] hex_code(input int nib, input bit upper);
        if (nib < 10)
            return CHAR_ZERO + CODE_W'(nib);
        return (upper ? CHAR_UC_A : CHAR_LC_A) + CODE_W'(nib) - HEX_ALPHA_BASE;
    endfunction

    function automatic bit is_dash_pos(input int p);
        return p == POS_DASH_A || p == POS_DASH_B || p == POS_DASH_C || p == POS_DASH_D;
    endfunction

    // Advance the predicted parser state by one accepted character
    task automatic track_char(input in_item_t item);
        logic [4:0]       nib;
        logic [POS_W-1:0] pos;
        out_item_t        res;
        pos = guess_pos;
        if (pos >= TEXT_LEN)
            guess_bad = 1'b1;
        else if (pos == POS_OPEN)
        begin
            if (item.char_code != CHAR_LBRACE)
                guess_bad = 1'b1;
        end
        else if (pos == POS_CLOSE)
        begin
            if (item.char_code != CHAR_RBRACE)
                guess_bad = 1'b1;
        end
        else if (is_dash_pos(int'(pos)))
        begin
            if (item.char_code != CHAR_DASH)
                guess_bad = 1'b1;
        end
        else
        begin
            nib = decode_hex(item.char_code);
            if (nib[4])
            begin
                guess_bad = 1'b1;
                nib = '0;
            end
            guess_high = {guess_high[59:0], guess_low[63:60]};
            guess_low  = {guess_low[59:0], nib[3:0]};
        end
        if (guess_pos < POS_SATURATE)
            guess_pos = guess_pos + 1'b1;

        if (item.last)
        begin
            if (pos != POS_CLOSE)
                guess_bad = 1'b1;
            if (guess_bad)
            begin
                res = '0;
                res.status = STATUS_INVALID;
            end
            else
            begin
                res.data1  = guess_high[63:32];
                res.data2  = guess_high[31:16];
                res.data3  = guess_high[15:0];
                res.data4  = guess_low;
                res.status = STATUS_OK;
            end
            guid_results_due.push_back(res);
            string_count++;
            guess_pos  = '0;
            guess_high = '0;
            guess_low  = '0;
            guess_bad  = 1'b0;
        end
    endtask

    // Send one character, idling first at the current rate
    task automatic send_char(input logic [CODE_W-1:0] code, input logic last);
        in_item_t item;
        item = '{char_code: code, last: last};
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        track_char(item);
        char_count++;
    endtask

    task automatic send_text();
        foreach (text_buf[i])
            send_char(text_buf[i], i == text_buf.size() - 1);
    endtask

    // Fill the text buffer with a well-formed GUID of random digits and case
    task automatic build_guid();
        text_buf = {};
        for (int p = 0; p < TEXT_LEN; p++)
        begin
            if (p == POS_OPEN)
                text_buf.push_back(CHAR_LBRACE);
            else if (p == POS_CLOSE)
                text_buf.push_back(CHAR_RBRACE);
            else if (is_dash_pos(p))
                text_buf.push_back(CHAR_DASH);
            else
                text_buf.push_back(hex_code($urandom_range(15), $urandom_range(1)));
        end
    endtask

    // Pick a character that is wrong at position p
    function automatic logic [CODE_W-1:0] wrong_char(input int p);
        logic [CODE_W-1:0] near_miss[11];
        logic [CODE_W-1:0] code;
        logic [4:0]        nib;
        near_miss = '{16'h002F, 16'h003A, 16'h0040, 16'h0047, 16'h0060, 16'h0067,
                      CHAR_LBRACE, CHAR_RBRACE, CHAR_DASH, 16'h0130, 16'h0161};
        forever
        begin
            case ($urandom_range(3))
                0: code = CODE_W'($urandom_range(16'hFFFF));
                1: code = hex_code($urandom_range(15), $urandom_range(1));
                default: code = near_miss[$urandom_range(10)];
            endcase
            nib = decode_hex(code);
            if (p == POS_OPEN && code != CHAR_LBRACE)
                return code;
            if (p == POS_CLOSE && code != CHAR_RBRACE)
                return code;
            if (is_dash_pos(p) && code != CHAR_DASH)
                return code;
            if (p != POS_OPEN && p != POS_CLOSE && !is_dash_pos(p) && nib[4])
                return code;
        end
    endfunction

    // Hold the input idle until every expected result is out
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (guid_results_due.size() != 0);
    endtask

    task automatic test_directed();
        // All digits at their top value, mixed case
        build_guid();
        foreach (text_buf[i])
            if (!(i == POS_OPEN || i == POS_CLOSE || is_dash_pos(i)))
                text_buf[i] = hex_code(15, i % 2);
        send_text();
        // All digits zero
        build_guid();
        foreach (text_buf[i])
            if (!(i == POS_OPEN || i == POS_CLOSE || is_dash_pos(i)))
                text_buf[i] = CHAR_ZERO;
        send_text();
        // One-character strings: the code extremes and the two braces
        send_char(16'hFFFF, 1'b1);
        send_char(16'h0000, 1'b1);
        send_char(CHAR_LBRACE, 1'b1);
        send_char(CHAR_RBRACE, 1'b1);
    endtask

    task automatic test_well_formed(input int n);
        repeat (n)
        begin
            build_guid();
            send_text();
        end
    endtask

    // One to three bad characters, anywhere, including the braces and dashes
    task automatic test_bad_chars(input int n);
        int p;
        repeat (n)
        begin
            build_guid();
            repeat ($urandom_range(1, 3))
            begin
                p = $urandom_range(TEXT_LEN - 1);
                text_buf[p] = wrong_char(p);
            end
            send_text();
        end
    endtask

    // Truncated strings and overlong strings of up to 70 characters
    task automatic test_wrong_length(input int n);
        int len;
        repeat (n)
        begin
            build_guid();
            if ($urandom_range(1))
            begin
                len = $urandom_range(1, TEXT_LEN - 1);
                while (text_buf.size() > len)
                    void'(text_buf.pop_back());
            end
            else
            begin
                len = $urandom_range(TEXT_LEN + 1, 70);
                while (text_buf.size() < len)
                    text_buf.push_back($urandom_range(1) ? CHAR_RBRACE :
                                       hex_code($urandom_range(15), $urandom_range(1)));
            end
            send_text();
        end
    endtask

    // Short strings of arbitrary code units
    task automatic test_noise(input int n);
        repeat (n)
        begin
            text_buf = {};
            repeat ($urandom_range(1, 5))
                text_buf.push_back(CODE_W'($urandom_range(16'hFFFF)));
            send_text();
        end
    endtask

    task automatic test_mixed(input int min_chars, input int min_strings);
        while (char_count < min_chars || string_count < min_strings)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: test_well_formed(1);
                5, 6:          test_bad_chars(1);
                7:             test_wrong_length(1);
                default:       test_noise(1);
            endcase
        end
    endtask

    // Receiver stalls at the current rate
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (guid_results_due.size() == 0)
            begin
                $error("unexpected result transfer: %p", out_data);
                fail_count++;
            end
            else
            begin
                want = guid_results_due.pop_front();
                if (out_data.data1 !== want.data1)
                begin
                    $error("data1 mismatch: expected %h, actual %h", want.data1, out_data.data1);
                    fail_count++;
                end
                if (out_data.data2 !== want.data2)
                begin
                    $error("data2 mismatch: expected %h, actual %h", want.data2, out_data.data2);
                    fail_count++;
                end
                if (out_data.data3 !== want.data3)
                begin
                    $error("data3 mismatch: expected %h, actual %h", want.data3, out_data.data3);
                    fail_count++;
                end
                if (out_data.data4 !== want.data4)
                begin
                    $error("data4 mismatch: expected %h, actual %h", want.data4, out_data.data4);
                    fail_count++;
                end
                if (out_data.status !== want.status)
                begin
                    $error("status mismatch: expected %b, actual %b",
                           want.status, out_data.status);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 38;
        recv_idle_pct = 49;
        test_directed();
        test_well_formed(6);
        test_bad_chars(7);
        drain_results();

        send_idle_pct = 49;
        recv_idle_pct = 38;
        test_wrong_length(6);
        test_noise(20);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_mixed(950, 48);

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
